FILE: hw/rtl/acmtm_pkg.sv
// Package for the alive counter and message timeout monitor.
// Shared op codes, event kinds and cell command types. No dependencies.
package acmtm_pkg;

	localparam int IdW   = 29;
	localparam int TimeW = 32;
	localparam int CfgW  = 16;
	localparam logic [3:0] AliveSna = 4'd15;

	localparam logic [1:0] OpTick  = 2'd0;
	localparam logic [1:0] OpAlive = 2'd1;
	localparam logic [1:0] OpMsg   = 2'd2;
	localparam logic [1:0] OpQuery = 2'd3;

	localparam logic [2:0] EvDone     = 3'd0;
	localparam logic [2:0] EvHbLost   = 3'd1;
	localparam logic [2:0] EvHbRest   = 3'd2;
	localparam logic [2:0] EvMsgTo    = 3'd3;
	localparam logic [2:0] EvTblFull  = 3'd4;

	localparam logic [1:0] RegHb     = 2'd0;
	localparam logic [1:0] RegMsg    = 2'd1;
	localparam logic [1:0] RegPeriod = 2'd2;

	// broadcast command to all cells
	typedef struct packed {
		logic             write;   // write id/time into selected cell
		logic [IdW-1:0]   id;
		logic [TimeW-1:0] now;
	} cell_cmd_t;

	// per-cell status seen by the controller
	typedef struct packed {
		logic           valid;
		logic           expired;
		logic           hit;
		logic [IdW-1:0] id;
	} cell_stat_t;

endpackage

FILE: hw/rtl/acmtm_cell.sv
// One table entry of the message timeout monitor.
// Holds id, arrival time and marks; a scan token passes from cell to cell.
// Depends on acmtm_pkg.
module acmtm_cell
	import acmtm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cell_cmd_t        cmd,
	input  logic             sel,       // write target of this cycle
	input  logic             adv,       // token may move this cycle
	input  logic             scan_in,   // token from left neighbor
	input  logic [CfgW-1:0]  msg_to,
	output logic             scan_out,  // token to right neighbor
	output logic             fire,      // this cell times out now
	output cell_stat_t       stat
);

	logic             valid_q;
	logic             expired_q;
	logic             token_q;
	logic [IdW-1:0]   id_q;
	logic [TimeW-1:0] seen_q;
	logic [TimeW-1:0] age;

	assign age  = cmd.now - seen_q;
	assign fire = token_q && valid_q && !expired_q && (age > {16'd0, msg_to});
	assign scan_out = token_q;

	assign stat.valid   = valid_q;
	assign stat.expired = expired_q;
	assign stat.hit     = valid_q && (id_q == cmd.id);
	assign stat.id      = id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			expired_q <= 1'b0;
			token_q   <= 1'b0;
		end else begin
			if (adv) token_q <= scan_in;
			if (cmd.write && sel) begin
				valid_q   <= 1'b1;
				expired_q <= 1'b0;
			end else if (fire && adv) begin
				expired_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write && sel) begin
			id_q   <= cmd.id;
			seen_q <= cmd.now;
		end
	end

endmodule

FILE: hw/rtl/alive_counter_message_timeout_monitor.sv
// Alive counter and message timeout monitor, top level: control, config, cells.
// An accepted item passes StExec, then StDone, which emits the done result;
// a check tick passes StScan in between, walking one cell per cycle while
// the output is free. Stalls hold each state; one item is taken at a time.
// Reset: asynchronous, clears control, marks and config to defaults.
// Depends on acmtm_pkg and acmtm_cell.
module alive_counter_message_timeout_monitor
	import acmtm_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       op,
	input  logic [3:0]       alive_count,
	input  logic [IdW-1:0]   message_id,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       event_kind,
	output logic [IdW-1:0]   event_id,
	output logic             query_timed_out,
	output logic             heartbeat_good,
	output logic             last
);

	typedef enum logic [3:0] {
		StIdle = 4'b0001,
		StExec = 4'b0010,
		StScan = 4'b0100,
		StDone = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic [CfgW-1:0]  hb_to_q, msg_to_q, period_q;
	logic [TimeW-1:0] now_q, alive_time_q, now_d, alive_time_d;
	logic [CfgW-1:0]  countdown_q, countdown_d;
	logic [3:0]       last_alive_q, last_alive_d;
	logic             hb_q, hb_d;
	logic             check_q, check_d;
	logic [1:0]       op_q;
	logic [3:0]       alive_in_q;
	logic [IdW-1:0]   id_in_q;
	logic             q_ans_q, q_ans_d;

	logic             ovalid_q, ovalid_d;
	logic [2:0]       okind_q, okind_d;
	logic [IdW-1:0]   oid_q, oid_d;
	logic             oq_q, oq_d;
	logic             olast_q, olast_d;

	cell_cmd_t                 cmd;
	cell_stat_t                stat   [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]    fire;
	logic [TABLE_DEPTH-1:0]    sel;
	logic [TABLE_DEPTH:0]      chain;
	logic                      start_scan;

	// config port
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			RegHb:     prdata = {16'd0, hb_to_q};
			RegMsg:    prdata = {16'd0, msg_to_q};
			RegPeriod: prdata = {16'd0, period_q};
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hb_to_q  <= 16'd1000;
			msg_to_q <= 16'd1000;
			period_q <= 16'd100;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				RegHb:     hb_to_q  <= pwdata[15:0];
				RegMsg:    msg_to_q <= pwdata[15:0];
				RegPeriod: period_q <= pwdata[15:0];
				default:   ;
			endcase
		end
	end

	// lookup across cells
	logic             any_hit, any_free, hit_exp;
	logic [TABLE_DEPTH-1:0] hit_oh, free_oh;
	always_comb begin
		any_hit = 1'b0;
		any_free = 1'b0;
		hit_exp = 1'b0;
		hit_oh = '0;
		free_oh = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (stat[i].hit && !any_hit) begin
				hit_oh[i] = 1'b1;
				hit_exp = stat[i].expired;
				any_hit = 1'b1;
			end
			if (!stat[i].valid && !any_free) begin
				free_oh[i] = 1'b1;
				any_free = 1'b1;
			end
		end
	end

	logic [CfgW-1:0]  cd_load, cd_next;
	assign cd_load = (countdown_q == '0) ? ((period_q == '0) ? 16'd1 : period_q) : countdown_q;
	assign cd_next = cd_load - 16'd1;

	logic ofree;
	assign ofree = !ovalid_q || out_ready;

	logic exec;
	assign exec = (state_q == StExec) && ofree;
	assign cmd.id    = id_in_q;
	assign cmd.now   = now_q;
	assign cmd.write = exec && (op_q == OpMsg) && (any_hit || any_free);
	assign sel       = any_hit ? hit_oh : free_oh;

	// token moves only while the output register can take a result
	logic scan_adv;
	assign scan_adv = ofree;
	assign chain[0] = start_scan;

	logic [IdW-1:0] fire_id;
	logic           any_fire;
	always_comb begin
		fire_id = '0;
		any_fire = 1'b0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (fire[i]) begin
				fire_id = stat[i].id;
				any_fire = 1'b1;
			end
		end
	end

	genvar g;
	generate
		for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
			logic tok_out;
			acmtm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cmd      (cmd),
				.sel      (sel[g]),
				.adv      (scan_adv),
				.scan_in  (chain[g]),
				.msg_to   (msg_to_q),
				.scan_out (tok_out),
				.fire     (fire[g]),
				.stat     (stat[g])
			);
			assign chain[g+1] = tok_out;
		end
	endgenerate

	assign in_ready = (state_q == StIdle);
	assign out_valid = ovalid_q;
	assign event_kind = okind_q;
	assign event_id = oid_q;
	assign query_timed_out = oq_q;
	assign heartbeat_good = hb_q;
	assign last = olast_q;

	logic hb_lost_now;
	assign hb_lost_now = hb_q && ((now_q - alive_time_q) > {16'd0, hb_to_q});

	logic new_alive;
	assign new_alive = (alive_in_q != AliveSna) && (alive_in_q != last_alive_q);

	assign start_scan = exec && (op_q == OpTick) && check_q;

	always_comb begin
		state_d      = state_q;
		now_d        = now_q;
		alive_time_d = alive_time_q;
		countdown_d  = countdown_q;
		last_alive_d = last_alive_q;
		hb_d         = hb_q;
		check_d      = check_q;
		q_ans_d      = q_ans_q;
		ovalid_d     = ovalid_q && !out_ready;
		okind_d      = okind_q;
		oid_d        = oid_q;
		oq_d         = oq_q;
		olast_d      = olast_q;
		unique case (state_q)
			StIdle: begin
				if (in_valid) begin
					state_d = StExec;
					check_d = 1'b0;
					if (op == OpTick) begin
						now_d       = now_q + 32'd1;
						countdown_d = cd_next;
						check_d     = (cd_next == '0);
					end
				end
			end
			StExec: begin
				if (ofree) begin
					state_d = StDone;
					q_ans_d = 1'b0;
					unique case (op_q)
						OpTick: begin
							if (check_q) begin
								state_d = StScan;
								if (hb_lost_now) begin
									hb_d     = 1'b0;
									ovalid_d = 1'b1;
									okind_d  = EvHbLost;
									oid_d    = '0;
									oq_d     = 1'b0;
									olast_d  = 1'b0;
								end
							end
						end
						OpAlive: begin
							if (new_alive) begin
								last_alive_d = alive_in_q;
								alive_time_d = now_q;
								if (!hb_q) begin
									hb_d     = 1'b1;
									ovalid_d = 1'b1;
									okind_d  = EvHbRest;
									oid_d    = '0;
									oq_d     = 1'b0;
									olast_d  = 1'b0;
								end
							end
						end
						OpMsg: begin
							if (!any_hit && !any_free) begin
								ovalid_d = 1'b1;
								okind_d  = EvTblFull;
								oid_d    = id_in_q;
								oq_d     = 1'b0;
								olast_d  = 1'b0;
							end
						end
						default: begin
							q_ans_d = !any_hit || hit_exp;
						end
					endcase
				end
			end
			StScan: begin
				if (ofree) begin
					if (any_fire) begin
						ovalid_d = 1'b1;
						okind_d  = EvMsgTo;
						oid_d    = fire_id;
						oq_d     = 1'b0;
						olast_d  = 1'b0;
					end
					if (chain[TABLE_DEPTH]) state_d = StDone;
				end
			end
			StDone: begin
				if (ofree) begin
					ovalid_d = 1'b1;
					okind_d  = EvDone;
					oid_d    = '0;
					oq_d     = q_ans_q;
					olast_d  = 1'b1;
					state_d  = StIdle;
				end
			end
			default: state_d = StIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= StIdle;
			now_q        <= '0;
			alive_time_q <= '0;
			countdown_q  <= '0;
			last_alive_q <= AliveSna;
			hb_q         <= 1'b1;
			check_q      <= 1'b0;
			q_ans_q      <= 1'b0;
			ovalid_q     <= 1'b0;
			okind_q      <= EvDone;
			oid_q        <= '0;
			oq_q         <= 1'b0;
			olast_q      <= 1'b0;
		end else begin
			state_q      <= state_d;
			now_q        <= now_d;
			alive_time_q <= alive_time_d;
			countdown_q  <= countdown_d;
			last_alive_q <= last_alive_d;
			hb_q         <= hb_d;
			check_q      <= check_d;
			q_ans_q      <= q_ans_d;
			ovalid_q     <= ovalid_d;
			okind_q      <= okind_d;
			oid_q        <= oid_d;
			oq_q         <= oq_d;
			olast_q      <= olast_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q       <= op;
			alive_in_q <= alive_count;
			id_in_q    <= message_id;
		end
	end

endmodule

FILE: hw/rtl/acmtm_checker.sv
// Port-level checker for the alive counter and message timeout monitor.
// Bound to the top level; depends on acmtm_pkg.
module acmtm_checker
	import acmtm_pkg::*;
(
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input logic [2:0]     event_kind,
	input logic [IdW-1:0] event_id,
	input logic           last
);

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (event_kind == EvDone)))
		else $error("last mismatch");

	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == EvDone || event_kind == EvHbLost
			|| event_kind == EvHbRest) |-> event_id == '0)
		else $error("event id not zero");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_kind))
		else $error("output dropped");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken early");

endmodule

bind alive_counter_message_timeout_monitor acmtm_checker u_acmtm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.event_kind (event_kind),
	.event_id   (event_id),
	.last       (last)
);

FILE: tb/testbench.sv
// Testbench for alive_counter_message_timeout_monitor: directed and random items,
// checked against an in-bench predictor of heartbeat and message-timeout supervision.
// Depends on acmtm_pkg and the monitor RTL.
`timescale 1ns / 100ps

module testbench;
	import acmtm_pkg::*;

	localparam int Depth = 16;
	localparam longint CycleLimit = 400000;

	typedef struct packed {
		logic [2:0]     kind;
		logic [IdW-1:0] id;
		logic           qto;
		logic           hb;
		logic           lst;
	} event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = OpTick;
	logic [3:0] alive_count = '0;
	logic [IdW-1:0] message_id = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] event_kind;
	logic [IdW-1:0] event_id;
	logic query_timed_out, heartbeat_good, last;

	alive_counter_message_timeout_monitor #(.TABLE_DEPTH(Depth)) i_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// supervisor state
	logic [15:0] hb_timeout, msg_timeout, period;
	logic [31:0] now_ms, hb_seen;
	logic [15:0] countdown;
	logic [3:0] last_alive;
	logic hb_ok;
	logic ent_valid [Depth];
	logic ent_expired [Depth];
	logic [IdW-1:0] ent_id [Depth];
	logic [31:0] ent_time [Depth];

	event_t pending_events[$];
	int errors = 0;
	int items_sent = 0;
	int events_seen = 0;
	int kind_seen [5];
	longint cycles = 0;
	bit rx_quiet = 1'b0;
	bit tx_quiet = 1'b0;
	logic [IdW-1:0] known_ids[$];

	task automatic report_mismatch(input string what, input logic [31:0] got, exp);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
		errors++;
	endtask

	function automatic int lookup(input logic [IdW-1:0] id);
		for (int i = 0; i < Depth; i++)
			if (ent_valid[i] && ent_id[i] == id) return i;
		return -1;
	endfunction

	task automatic predict_item(input logic [1:0] o, input logic [3:0] a,
			input logic [IdW-1:0] id);
		event_t evs[$];
		event_t e;
		int idx;
		logic q;
		q = 1'b0;
		case (o)
			OpTick: begin
				now_ms = now_ms + 32'd1;
				if (countdown == 0) countdown = (period == 0) ? 16'd1 : period;
				countdown = countdown - 16'd1;
				if (countdown == 0) begin
					if (hb_ok && (now_ms - hb_seen) > {16'd0, hb_timeout}) begin
						hb_ok = 1'b0;
						evs.push_back('{EvHbLost, '0, 1'b0, 1'b0, 1'b0});
					end
					for (int i = 0; i < Depth; i++)
						if (ent_valid[i] && !ent_expired[i] &&
								(now_ms - ent_time[i]) > {16'd0, msg_timeout}) begin
							ent_expired[i] = 1'b1;
							evs.push_back('{EvMsgTo, ent_id[i], 1'b0, 1'b0, 1'b0});
						end
				end
			end
			OpAlive: begin
				if (a != AliveSna && a != last_alive) begin
					last_alive = a;
					hb_seen = now_ms;
					if (!hb_ok) begin
						hb_ok = 1'b1;
						evs.push_back('{EvHbRest, '0, 1'b0, 1'b0, 1'b0});
					end
				end
			end
			OpMsg: begin
				idx = lookup(id);
				if (idx < 0)
					for (int i = Depth - 1; i >= 0; i--)
						if (!ent_valid[i]) idx = i;
				if (idx >= 0) begin
					ent_valid[idx] = 1'b1;
					ent_id[idx] = id;
					ent_time[idx] = now_ms;
					ent_expired[idx] = 1'b0;
				end else
					evs.push_back('{EvTblFull, id, 1'b0, 1'b0, 1'b0});
			end
			default: begin
				idx = lookup(id);
				q = (idx < 0) ? 1'b1 : ent_expired[idx];
			end
		endcase
		evs.push_back('{EvDone, '0, q, 1'b0, 1'b1});
		foreach (evs[i]) begin
			e = evs[i];
			e.hb = hb_ok;
			pending_events.push_back(e);
		end
	endtask

	task automatic send_item(input logic [1:0] o, input logic [3:0] a,
			input logic [IdW-1:0] id);
		while (!tx_quiet && $urandom_range(99) < 32) @(posedge clk);
		predict_item(o, a, id);
		in_valid <= 1'b1;
		op <= o;
		alive_count <= a;
		message_id <= id;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		in_valid <= 1'b0;
		items_sent++;
		// the monitor stays busy after an accept, in StExec and then StDone
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_events.size() != 0) @(posedge clk);
		repeat (Depth + 6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			RegHb: hb_timeout = val;
			RegMsg: msg_timeout = val;
			default: period = val;
		endcase
	endtask

	task automatic ticks(input int n);
		repeat (n) send_item(OpTick, 4'($urandom), IdW'($urandom));
	endtask

	task automatic test_directed_extremes();
		write_reg(RegHb, 16'd3);
		write_reg(RegMsg, 16'd2);
		write_reg(RegPeriod, 16'd1);
		send_item(OpQuery, 4'd0, '1);
		send_item(OpAlive, AliveSna, '0);
		send_item(OpAlive, 4'd0, '0);
		send_item(OpAlive, 4'd0, '0);
		send_item(OpMsg, 4'hf, '1);
		send_item(OpMsg, 4'h0, '0);
		send_item(OpMsg, 4'h5, 29'h0AAAAAAA);
		send_item(OpMsg, 4'hA, 29'h15555555);
		send_item(OpQuery, 4'hf, '1);
		ticks(5);
		send_item(OpQuery, 4'h0, '1);
		send_item(OpMsg, 4'h0, '1);
		send_item(OpQuery, 4'h0, '1);
		send_item(OpAlive, 4'd7, '0);
		send_item(OpAlive, 4'd15, '0);
		drain();
	endtask

	task automatic test_table_full();
		for (int i = 0; i < Depth + 2; i++)
			send_item(OpMsg, 4'($urandom), IdW'(29'h100 + i));
		send_item(OpMsg, 4'd0, 29'h105);
		drain();
	endtask

	task automatic test_random(input int n);
		logic [1:0] o;
		logic [IdW-1:0] id;
		for (int k = 0; k < n; k++) begin
			if (k == n / 2) begin
				drain();
				tx_quiet = 1'b1;
				rx_quiet = 1'b1;
			end
			if (k == n / 2 + 20) begin
				tx_quiet = 1'b0;
				rx_quiet = 1'b0;
			end
			o = 2'($urandom_range(3));
			if ($urandom_range(3) == 0) o = OpTick;
			if ($urandom_range(1) == 0 || known_ids.size() == 0)
				id = ($urandom_range(3) == 0) ? IdW'($urandom) : IdW'($urandom_range(40));
			else
				id = known_ids[$urandom_range(known_ids.size() - 1)];
			if (o == OpMsg) known_ids.push_back(id);
			send_item(o, 4'($urandom), id);
		end
		drain();
	endtask

	task automatic test_config_sweep();
		write_reg(RegPeriod, 16'd65535);
		write_reg(RegHb, 16'd65535);
		write_reg(RegMsg, 16'd65535);
		ticks(3);
		send_item(OpQuery, 4'd0, 29'h100);
		drain();
		write_reg(RegPeriod, 16'd2);
		write_reg(RegHb, 16'd1);
		write_reg(RegMsg, 16'd1);
	endtask

	always @(posedge clk) begin
		event_t exp;
		cycles++;
		if (cycles > CycleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
		if (arst_n) begin
			if (out_valid && out_ready) begin
				events_seen++;
				if (pending_events.size() == 0) report_mismatch("unexpected result", 0, 0);
				else begin
					exp = pending_events.pop_front();
					if (event_kind <= 3'd4) kind_seen[event_kind]++;
					if (event_kind !== exp.kind) report_mismatch("event_kind", event_kind, exp.kind);
					if (event_id !== exp.id) report_mismatch("event_id", event_id, exp.id);
					if (query_timed_out !== exp.qto)
						report_mismatch("query_timed_out", query_timed_out, exp.qto);
					if (heartbeat_good !== exp.hb)
						report_mismatch("heartbeat_good", heartbeat_good, exp.hb);
					if (last !== exp.lst) report_mismatch("last", last, exp.lst);
				end
			end
			out_ready <= rx_quiet || ($urandom_range(99) >= 32);
		end
	end

	initial begin
		hb_timeout = 16'd1000;
		msg_timeout = 16'd1000;
		period = 16'd100;
		now_ms = '0;
		hb_seen = '0;
		countdown = '0;
		last_alive = AliveSna;
		hb_ok = 1'b1;
		for (int i = 0; i < Depth; i++) begin
			ent_valid[i] = 1'b0;
			ent_expired[i] = 1'b0;
			ent_id[i] = '0;
			ent_time[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_table_full();
		test_config_sweep();
		test_random(68);
		$display("items sent %0d, results checked %0d", items_sent, events_seen);
		$display("kinds done/lost/restored/timeout/full: %0d %0d %0d %0d %0d",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
		if (errors == 0 && pending_events.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
